// File: sv/mpcls_pkg.sv
// Shared constants, types and widths for the masked path count launch sizer.
// No dependencies; imported by mpcls_div and masked_path_count_launch_sizer.
package mpcls_pkg;

   localparam int MAX_WALK  = 20;
   localparam int MAX_ROWS  = 28;
   localparam int HSIZE     = MAX_WALK + 3;   // height slots 0..22
   localparam int HW        = $clog2(HSIZE);  // height counter width
   localparam int HC_W      = 32;             // free walk counts, up to 3^20
   localparam int LC_W      = 21;             // masked walk counts, up to 2^20
   localparam int PATH_W    = 52;
   localparam int GRP_W     = 16;
   localparam int THR_W     = 11;
   localparam int LEN_W     = 5;
   localparam int MASK_W    = 20;
   localparam int QREM_W    = GRP_W + THR_W;  // remainder width of divider

   localparam logic [GRP_W-1:0] SAT16 = 16'hFFFF;

   // register indexes
   localparam logic [1:0] REG_LOW_BITS = 2'd0;
   localparam logic [1:0] REG_HIGH_LEN = 2'd1;
   localparam logic [1:0] REG_THREADS  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_MUL,
      ST_DENSE,
      ST_ROW_ADV,
      ST_ROW_DIV,
      ST_OUT
   } state_type;

endpackage

// File: sv/masked_path_count_launch_sizer.sv
// Top level of the masked path count launch sizer: sequencer, count rings,
// multiplier/accumulator and output register. Depends on mpcls_pkg, mpcls_div.
//
// Usage:
//   req_ carries one occupancy mask per word (tdata[19:0]). For each mask the
//   block returns W = low_bits + high_len + 1 words on rsp_, rows 1..W, with
//   tlast on row W. An invalid size (W outside 4..28, a length outside 1..20,
//   or threads of 0) gives one word with tuser set, tlast set, data zero.
//   csr_ writes the three size registers; write only while idle.
// Sequencing:
//   One mask at a time; req_tready is high only while idle.
//   Path counting: max(low_bits, high_len) passes over the 23 height slots,
//   one height per cycle through the shared update adder pair.
//   Products: slot by slot through one 32x21 multiplier and the accumulator.
//   Each ceiling division runs in mpcls_div (one quotient bit per cycle);
//   one for the dense total, then one per row, after a step of the prefix
//   ring in ST_ROW_ADV; each row word then passes through the output register.
// Reset: sync, active high; registers return to 14 / 13 / 256, block idle.
// Stall: a row word stays in the output register until rsp_tready; the
//   sequencer holds and nothing is dropped.
module masked_path_count_launch_sizer (
   input  logic         clock,
   input  logic         reset,
   // req_tdata: occupancy_mask[19:0], zero pad [23:20]
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,
   // rsp_tdata: row_index[4:0], row_groups[20:5], row_cut[21],
   //            dense_groups[37:22], block_paths[89:38], zero pad [95:90]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,
   output logic         rsp_tlast,   // last_row
   output logic         rsp_tuser,   // config_error
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [10:0]  csr_wdata
);
   import mpcls_pkg::*;

   state_type state_ff, state_in;

   // size registers
   logic [LEN_W-1:0] low_ff, low_in;
   logic [LEN_W-1:0] high_ff, high_in;
   logic [THR_W-1:0] thr_ff, thr_in;

   // count rings: slot 0 is the height being updated this cycle
   logic [HC_W-1:0]   hc_ff [0:HSIZE-1];
   logic [HC_W-1:0]   hc_in [0:HSIZE-1];
   logic [LC_W-1:0]   lc_ff [0:HSIZE-1];
   logic [LC_W-1:0]   lc_in [0:HSIZE-1];
   logic [PATH_W-1:0] pf_ff [0:HSIZE-1];
   logic [PATH_W-1:0] pf_in [0:HSIZE-1];
   logic [HC_W-1:0]   hprev_ff, hprev_in;   // old count one height below
   logic [LC_W-1:0]   lprev_ff, lprev_in;

   logic [MASK_W-1:0] mask_ff, mask_in;
   logic [LEN_W-1:0]  pass_ff, pass_in;
   logic [LEN_W-1:0]  npass_ff, npass_in;
   logic [HW-1:0]     h_ff, h_in;
   logic [PATH_W-1:0] prod_ff, prod_in;
   logic [PATH_W-1:0] acc_ff, acc_in;
   logic [GRP_W-1:0]  dense_ff, dense_in;
   logic [LEN_W-1:0]  row_ff, row_in;
   logic [LEN_W:0]    rows_ff, rows_in;

   // output register
   logic              ov_ff, ov_in;
   logic [95:0]       od_ff, od_in;
   logic              olast_ff, olast_in;
   logic              oerr_ff, oerr_in;

   // divider
   logic              div_start;
   logic [PATH_W-1:0] div_n;
   logic              div_done;
   logic [GRP_W-1:0]  div_q;

   logic [LEN_W:0]    w_sum;
   logic              cfg_bad;
   logic [HC_W-1:0]   hc_next_up;
   logic [HC_W-1:0]   hc_new;
   logic [LC_W-1:0]   lc_next_up;
   logic [LC_W-1:0]   lc_new;
   logic [PATH_W-1:0] acc_sum;
   logic [HC_W+LC_W-1:0] mul_full;   // full product, always below 2^52
   logic              row_cut;

   mpcls_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_n),
      .divisor  (thr_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      w_sum   = (LEN_W+1)'(low_ff) + (LEN_W+1)'(high_ff) + (LEN_W+1)'(1);
      cfg_bad = (low_ff < LEN_W'(1)) || (low_ff > LEN_W'(MAX_WALK)) ||
                (high_ff < LEN_W'(1)) || (high_ff > LEN_W'(MAX_WALK)) ||
                (w_sum < (LEN_W+1)'(4)) || (w_sum > (LEN_W+1)'(MAX_ROWS)) ||
                (thr_ff == '0);

      // free walk: stay, down, up; top slot has no neighbor above
      hc_next_up = (h_ff != HW'(HSIZE-1)) ? hc_ff[1] : '0;
      hc_new     = (pass_ff < high_ff) ? (hprev_ff + hc_ff[0] + hc_next_up) : hc_ff[0];

      // masked walk: heights above low_bits+1 stay empty
      lc_next_up = (h_ff != HW'(HSIZE-1)) ? lc_ff[1] : '0;
      if (pass_ff >= low_ff) begin
         lc_new = lc_ff[0];
      end else if ((LEN_W+1)'(h_ff) > (LEN_W+1)'(low_ff) + (LEN_W+1)'(1)) begin
         lc_new = '0;
      end else if (mask_ff[0]) begin
         lc_new = lprev_ff + lc_next_up;
      end else begin
         lc_new = lc_ff[0];
      end

      mul_full = hc_ff[0] * lc_ff[0];
      acc_sum  = acc_ff + prod_ff;
      row_cut  = div_q < dense_ff;
   end

   always_comb begin
      state_in  = state_ff;
      low_in    = low_ff;
      high_in   = high_ff;
      thr_in    = thr_ff;
      hc_in     = hc_ff;
      lc_in     = lc_ff;
      pf_in     = pf_ff;
      hprev_in  = hprev_ff;
      lprev_in  = lprev_ff;
      mask_in   = mask_ff;
      pass_in   = pass_ff;
      npass_in  = npass_ff;
      h_in      = h_ff;
      prod_in   = prod_ff;
      acc_in    = acc_ff;
      dense_in  = dense_ff;
      row_in    = row_ff;
      rows_in   = rows_ff;
      ov_in     = ov_ff;
      od_in     = od_ff;
      olast_in  = olast_ff;
      oerr_in   = oerr_ff;
      div_start = 1'b0;
      div_n     = acc_ff;

      if (csr_we) begin
         unique case (csr_index)
            REG_LOW_BITS: low_in  = csr_wdata[LEN_W-1:0];
            REG_HIGH_LEN: high_in = csr_wdata[LEN_W-1:0];
            REG_THREADS:  thr_in  = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (cfg_bad) begin
                  ov_in    = 1'b1;
                  od_in    = '0;
                  olast_in = 1'b1;
                  oerr_in  = 1'b1;
                  state_in = ST_OUT;
               end else begin
                  for (int i = 0; i < HSIZE; i++) begin
                     hc_in[i] = '0;
                     lc_in[i] = '0;
                  end
                  hc_in[1] = HC_W'(1);
                  lc_in[0] = LC_W'(1);
                  hprev_in = '0;
                  lprev_in = '0;
                  mask_in  = req_tdata[MASK_W-1:0];
                  pass_in  = '0;
                  npass_in = (low_ff > high_ff) ? low_ff : high_ff;
                  h_in     = '0;
                  rows_in  = w_sum;
                  state_in = ST_SWEEP;
               end
            end
         end

         ST_SWEEP: begin
            for (int i = 0; i < HSIZE - 1; i++) begin
               hc_in[i] = hc_ff[i+1];
               lc_in[i] = lc_ff[i+1];
            end
            hc_in[HSIZE-1] = hc_new;
            lc_in[HSIZE-1] = lc_new;
            if (h_ff == HW'(HSIZE-1)) begin
               hprev_in = '0;
               lprev_in = '0;
               h_in     = '0;
               mask_in  = mask_ff >> 1;
               pass_in  = pass_ff + LEN_W'(1);
               if (pass_ff + LEN_W'(1) == npass_ff) begin
                  acc_in   = '0;
                  state_in = ST_MUL;
               end
            end else begin
               hprev_in = hc_ff[0];
               lprev_in = lc_ff[0];
               h_in     = h_ff + HW'(1);
            end
         end

         ST_MUL: begin
            // slot h multiplies; the product of slot h-1 accumulates
            if (h_ff != HW'(HSIZE)) begin
               prod_in = mul_full[PATH_W-1:0];
               for (int i = 0; i < HSIZE - 1; i++) begin
                  hc_in[i] = hc_ff[i+1];
                  lc_in[i] = lc_ff[i+1];
               end
               hc_in[HSIZE-1] = hc_ff[0];
               lc_in[HSIZE-1] = lc_ff[0];
            end
            if (h_ff != '0) begin
               if ((LEN_W+1)'(h_ff - HW'(1)) <= (LEN_W+1)'(high_ff) + (LEN_W+1)'(1)) begin
                  acc_in = acc_sum;
               end
               for (int i = 0; i < HSIZE - 1; i++) begin
                  pf_in[i] = pf_ff[i+1];
               end
               pf_in[HSIZE-1] = ((LEN_W+1)'(h_ff - HW'(1)) <=
                                 (LEN_W+1)'(high_ff) + (LEN_W+1)'(1)) ? acc_sum : acc_ff;
            end
            if (h_ff == HW'(HSIZE)) begin
               div_start = 1'b1;
               div_n     = acc_sum;
               state_in  = ST_DENSE;
            end else begin
               h_in = h_ff + HW'(1);
            end
         end

         ST_DENSE: begin
            if (div_done) begin
               dense_in = div_q;
               row_in   = LEN_W'(1);
               state_in = ST_ROW_ADV;
            end
         end

         ST_ROW_ADV: begin
            // ring head walks up to prefix[high_len+1] and then stays
            if ((LEN_W+1)'(row_ff) <= (LEN_W+1)'(high_ff) + (LEN_W+1)'(1)) begin
               for (int i = 0; i < HSIZE - 1; i++) begin
                  pf_in[i] = pf_ff[i+1];
               end
               pf_in[HSIZE-1] = pf_ff[0];
               div_n = pf_ff[1];
            end else begin
               div_n = pf_ff[0];
            end
            div_start = 1'b1;
            state_in  = ST_ROW_DIV;
         end

         ST_ROW_DIV: begin
            if (div_done) begin
               ov_in    = 1'b1;
               od_in    = {6'd0, acc_ff, dense_ff, row_cut, div_q, row_ff};
               olast_in = ((LEN_W+1)'(row_ff) == rows_ff);
               oerr_in  = 1'b0;
               state_in = ST_OUT;
            end
         end

         ST_OUT: begin
            if (rsp_tready) begin
               ov_in = 1'b0;
               if (olast_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  row_in   = row_ff + LEN_W'(1);
                  state_in = ST_ROW_ADV;
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         low_ff   <= LEN_W'(14);
         high_ff  <= LEN_W'(13);
         thr_ff   <= THR_W'(256);
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         low_ff   <= low_in;
         high_ff  <= high_in;
         thr_ff   <= thr_in;
         ov_ff    <= ov_in;
      end
      hc_ff    <= hc_in;
      lc_ff    <= lc_in;
      pf_ff    <= pf_in;
      hprev_ff <= hprev_in;
      lprev_ff <= lprev_in;
      mask_ff  <= mask_in;
      pass_ff  <= pass_in;
      npass_ff <= npass_in;
      h_ff     <= h_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      dense_ff <= dense_in;
      row_ff   <= row_in;
      rows_ff  <= rows_in;
      od_ff    <= od_in;
      olast_ff <= olast_in;
      oerr_ff  <= oerr_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tuser  = oerr_ff;

endmodule

// File: sv/mpcls_div.sv
// Iterative ceiling divider, one quotient bit per cycle, saturating at 65535.
// Depends on mpcls_pkg.
module mpcls_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [mpcls_pkg::PATH_W-1:0]  dividend,
   input  logic [mpcls_pkg::THR_W-1:0]   divisor,
   output logic                          done,
   output logic [mpcls_pkg::GRP_W-1:0]   quotient
);
   import mpcls_pkg::*;

   logic              active_ff, active_in;
   logic              done_ff, done_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic [QREM_W-1:0] rem_ff, rem_in;
   logic [QREM_W-1:0] d_ff, d_in;
   logic [GRP_W-1:0]  q_ff, q_in;
   logic [GRP_W-1:0]  res_ff, res_in;

   logic [PATH_W-1:0] nm1;
   logic [PATH_W-1:0] sat_lim;
   logic [GRP_W-1:0]  q_step;
   logic [QREM_W-1:0] rem_step;

   always_comb begin
      nm1     = dividend - PATH_W'(1);
      // t * 65535 = (t << 16) - t
      sat_lim = (PATH_W'(divisor) << GRP_W) - PATH_W'(divisor);
      if (rem_ff >= d_ff) begin
         rem_step = rem_ff - d_ff;
         q_step   = {q_ff[GRP_W-2:0], 1'b1};
      end else begin
         rem_step = rem_ff;
         q_step   = {q_ff[GRP_W-2:0], 1'b0};
      end

      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      d_in      = d_ff;
      q_in      = q_ff;
      res_in    = res_ff;

      if (start) begin
         if (dividend == '0) begin
            res_in  = '0;
            done_in = 1'b1;
         end else if (nm1 >= sat_lim) begin
            res_in  = SAT16;
            done_in = 1'b1;
         end else begin
            rem_in    = nm1[QREM_W-1:0];
            d_in      = QREM_W'(divisor) << (GRP_W - 1);
            q_in      = '0;
            cnt_in    = 5'(GRP_W);
            active_in = 1'b1;
         end
      end else if (active_ff) begin
         rem_in = rem_step;
         q_in   = q_step;
         d_in   = d_ff >> 1;
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            active_in = 1'b0;
            done_in   = 1'b1;
            res_in    = q_step + GRP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      d_ff   <= d_in;
      q_ff   <= q_in;
      res_ff <= res_in;
   end

   assign done     = done_ff;
   assign quotient = res_ff;

endmodule

// File: dv/tb_masked_path_count_launch_sizer.sv
// Testbench for masked_path_count_launch_sizer: directed table, then random masks
// checked against an in-bench path count predictor. Depends on mpcls_pkg and the RTL.
`timescale 1ns / 100ps

module tb_masked_path_count_launch_sizer;
   import mpcls_pkg::*;

   localparam int SETTLE = 1500;    // cycles after last row before a register write
   localparam int WD_LIMIT = 20000; // cycles with no word moving
   localparam logic [1:0] REG_SPARE = 2'd3;   // index with no register behind it

   typedef struct packed {
      logic [4:0]  row_index;
      logic [15:0] row_groups;
      logic        row_cut;
      logic [15:0] dense_groups;
      logic [51:0] block_paths;
      logic        last_row;
      logic        config_error;
   } row_word_type;

   // directed stimulus row; typed set means the first row is typed in
   typedef struct {
      logic [19:0]  mask;
      bit           typed;
      row_word_type first_row;
   } dir_row_type;

   logic        clock, reset;
   logic        req_tvalid, req_tready;
   logic [23:0] req_tdata;
   logic        rsp_tvalid, rsp_tready;
   logic [95:0] rsp_tdata;
   logic        rsp_tlast, rsp_tuser;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [10:0] csr_wdata;

   masked_path_count_launch_sizer dut (.*);

   // predictor copy of the size registers
   logic [4:0]  size_low, size_high;
   logic [10:0] size_threads;

   row_word_type rows_due[$];
   int          fail_count = 0;
   int          idle_cycles = 0;
   bit          rsp_idle_on = 1;   // random receiver stalls
   bit          req_idle_on = 1;   // random sender gaps
   bit          long_hold = 0;     // receiver held off for a long stretch

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic logic [15:0] groups_of(logic [63:0] n, logic [10:0] t);
      logic [63:0] q;
      if (n == 0) return 16'd0;
      q = (n - 1) / t + 1;
      return (q > 64'd65535) ? 16'hFFFF : q[15:0];
   endfunction

   // expected row words for one mask under the current sizes
   task automatic predict_rows(input logic [19:0] mask);
      logic [63:0] free_cnt[HSIZE], masked_cnt[HSIZE], nxt[HSIZE], prefix[HSIZE];
      logic [63:0] total;
      logic [15:0] dense, br;
      int lo, hi, w, cap;
      row_word_type rw;
      lo = int'(size_low); hi = int'(size_high); w = lo + hi + 1;
      if (lo < 1 || lo > MAX_WALK || hi < 1 || hi > MAX_WALK || w < 4 || w > MAX_ROWS
          || size_threads == 0) begin
         rw = '0; rw.last_row = 1; rw.config_error = 1;
         rows_due.push_back(rw);
         return;
      end
      foreach (free_cnt[h]) begin free_cnt[h] = 0; masked_cnt[h] = 0; end
      free_cnt[1] = 1; masked_cnt[0] = 1;
      for (int p = 0; p < hi; p++) begin
         foreach (nxt[h]) nxt[h] = 0;
         for (int h = 0; h <= hi + 1 && h + 1 < HSIZE; h++) begin
            nxt[h] += free_cnt[h];
            if (h > 0) nxt[h-1] += free_cnt[h];
            nxt[h+1] += free_cnt[h];
         end
         free_cnt = nxt;
      end
      for (int p = 0; p < lo; p++) begin
         foreach (nxt[h]) nxt[h] = 0;
         for (int h = 0; h <= lo + 1; h++) begin
            if (!mask[p]) nxt[h] += masked_cnt[h];
            else begin
               if (h > 0) nxt[h-1] += masked_cnt[h];
               if (h + 1 <= lo + 1) nxt[h+1] += masked_cnt[h];
            end
         end
         masked_cnt = nxt;
      end
      total = 0;
      // heights past the masked table count as zero
      for (int h = 0; h <= hi + 1; h++) begin
         if (h <= lo + 1) total += free_cnt[h] * masked_cnt[h];
         prefix[h] = total;
      end
      dense = groups_of(total, size_threads);
      for (int r = 1; r <= w; r++) begin
         cap = (r < hi + 1) ? r : hi + 1;
         br = groups_of(prefix[cap], size_threads);
         rw.row_index = 5'(r); rw.row_groups = br; rw.row_cut = br < dense;
         rw.dense_groups = dense; rw.block_paths = total[51:0];
         rw.last_row = (r == w); rw.config_error = 0;
         rows_due.push_back(rw);
      end
   endtask

   // receiver: random stall bursts, or a long hold when asked
   int stall_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (long_hold) begin
         rsp_tready <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 0;
      end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
         stall_left <= int'($urandom_range(1, 9)) - 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= 1;
      end
   end

   // checker: compare each accepted word with the oldest expectation
   always @(posedge clock) begin
      row_word_type got, want;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_tvalid && rsp_tready) begin
            got.row_index    = rsp_tdata[4:0];
            got.row_groups   = rsp_tdata[20:5];
            got.row_cut      = rsp_tdata[21];
            got.dense_groups = rsp_tdata[37:22];
            got.block_paths  = rsp_tdata[89:38];
            got.last_row     = rsp_tlast;
            got.config_error = rsp_tuser;
            if (rows_due.size() == 0) begin
               $error("unexpected word row_index=%0d", got.row_index);
               fail_count++;
            end else begin
               want = rows_due.pop_front();
               if (got.row_index != want.row_index) begin
                  $error("row_index exp %0d got %0d", want.row_index, got.row_index);
                  fail_count++;
               end
               if (got.row_groups != want.row_groups) begin
                  $error("row_groups exp %0d got %0d", want.row_groups, got.row_groups);
                  fail_count++;
               end
               if (got.row_cut != want.row_cut) begin
                  $error("row_cut exp %0d got %0d", want.row_cut, got.row_cut);
                  fail_count++;
               end
               if (got.dense_groups != want.dense_groups) begin
                  $error("dense_groups exp %0d got %0d", want.dense_groups,
                         got.dense_groups);
                  fail_count++;
               end
               if (got.block_paths != want.block_paths) begin
                  $error("block_paths exp %0d got %0d", want.block_paths,
                         got.block_paths);
                  fail_count++;
               end
               if (got.last_row != want.last_row) begin
                  $error("last_row exp %0d got %0d", want.last_row, got.last_row);
                  fail_count++;
               end
               if (got.config_error != want.config_error) begin
                  $error("config_error exp %0d got %0d", want.config_error,
                         got.config_error);
                  fail_count++;
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (idle_cycles >= WD_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // offer one mask; predict when it is taken; valid drops on the accepting edge
   task automatic send_mask(input logic [19:0] mask);
      int gap;
      @(posedge clock);
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 9);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {4'd0, mask};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_rows(mask);
      req_tvalid <= 0;
   endtask

   // drain all expected rows, then let the block settle before register writes
   task automatic drain();
      while (rows_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
      csr_we <= 1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      @(posedge clock);
      case (idx)
         REG_LOW_BITS: size_low     = val[4:0];
         REG_HIGH_LEN: size_high    = val[4:0];
         REG_THREADS:  size_threads = val;
         default: ;  // unknown index is ignored
      endcase
   endtask

   task automatic set_sizes(input int lo, input int hi, input int thr);
      drain();
      write_reg(REG_LOW_BITS, 11'(lo));
      write_reg(REG_HIGH_LEN, 11'(hi));
      write_reg(REG_THREADS, 11'(thr));
   endtask

   dir_row_type dir_table[$];
   row_word_type first_due;

   initial begin
      int n_rand;
      row_word_type err_row;
      req_tvalid = 0; req_tdata = 0;
      csr_we = 0; csr_index = 0; csr_wdata = 0;
      size_low = 14; size_high = 13; size_threads = 256;
      reset = 1;
      repeat (9) @(posedge clock);
      reset <= 0;

      err_row = '0; err_row.last_row = 1; err_row.config_error = 1;

      // directed: reset sizes, extremes of the mask, alternating patterns
      dir_table.push_back('{20'h00000, 0, '0});
      dir_table.push_back('{20'hFFFFF, 0, '0});
      dir_table.push_back('{20'h55555, 0, '0});
      dir_table.push_back('{20'hAAAAA, 0, '0});
      dir_table.push_back('{20'h03FFF, 0, '0});
      dir_table.push_back('{20'hFC000, 0, '0});
      foreach (dir_table[i]) send_mask(dir_table[i].mask);

      // ignored register index; sizes unchanged
      drain();
      write_reg(REG_SPARE, 11'h7FF);
      send_mask(20'h12345);

      // invalid sizes: each gives a single error word; the first is typed in
      dir_table.delete();
      set_sizes(0, 5, 8);
      dir_table.push_back('{20'hFFFFF, 1, err_row});
      foreach (dir_table[i]) begin
         first_due = dir_table[i].first_row;
         send_mask(dir_table[i].mask);
         if (dir_table[i].typed && rows_due[rows_due.size()-1] != first_due) begin
            $error("first_row exp %h got %h", first_due, rows_due[rows_due.size()-1]);
            fail_count++;
         end
      end
      set_sizes(20, 20, 8);      send_mask(20'h0F0F0);  // W too large
      set_sizes(1, 1, 8);        send_mask(20'h00001);  // W too small
      set_sizes(21, 3, 8);       send_mask(20'h00001);
      set_sizes(5, 31, 8);       send_mask(20'h00001);
      set_sizes(5, 5, 0);        send_mask(20'h00001);  // threads zero

      // valid extremes; heights past the masked table exercised by high > low
      set_sizes(1, 2, 1);        send_mask(20'h00001); send_mask(20'h00000);
      set_sizes(2, 1, 1024);     send_mask(20'h00003);
      set_sizes(1, 20, 1);       send_mask(20'hFFFFF); send_mask(20'h00000);
      set_sizes(20, 7, 1);       send_mask(20'hFFFFF); send_mask(20'h00000);
      set_sizes(7, 20, 2047);    send_mask(20'h0007F);
      set_sizes(13, 14, 1);      send_mask(20'h01555);

      // random part across several size settings
      n_rand = 0;
      for (int phase = 0; phase < 9; phase++) begin
         int lo, hi;
         lo = $urandom_range(1, 20);
         hi = $urandom_range((lo < 3) ? 3 - lo : 1, 27 - lo > 20 ? 20 : 27 - lo);
         case (phase)
            0: set_sizes(lo, hi, 1);
            1: set_sizes(lo, hi, 1024);
            2: set_sizes(lo, hi, 2047);
            default: set_sizes(lo, hi, $urandom_range(1, 2047));
         endcase
         if (phase == 3) begin
            // long receiver hold once a row is waiting, while the sender keeps offering
            fork
               begin
                  long_hold = 1;
                  wait (rsp_tvalid);
                  repeat (400) @(posedge clock);
                  long_hold = 0;
               end
               repeat (3) send_mask(20'($urandom_range(0, 20'hFFFFF)));
            join
            n_rand += 3;
            // sender pauses until everything is back
            while (rows_due.size() != 0) @(posedge clock);
         end
         if (phase == 8) begin rsp_idle_on = 0; req_idle_on = 0; end
         repeat (48) begin
            send_mask(20'($urandom_range(0, 20'hFFFFF)));
            n_rand++;
         end
      end

      while (rows_due.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

endmodule
